FILE: hw/rtl/ewh_pkg.sv
// Shared types and constants of the equal-width histogram unit.
package ewh_pkg;

   localparam int BIN_COUNT_W = 7;
   localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RESET = 7'd16;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_FLAT    = 2'd1;
   localparam logic [1:0] ERR_DROPPED = 2'd2;

   // Sequencer states, one-hot.
   typedef enum logic [6:0] {
      ST_LOAD  = 7'b0000001,
      ST_CLEAR = 7'b0000010,
      ST_BIN   = 7'b0000100,
      ST_DIV   = 7'b0001000,
      ST_EMIT  = 7'b0010000,
      ST_WAIT  = 7'b0100000,
      ST_FETCH = 7'b1000000
   } state_type;

   // Jobs the shared divider runs for one emitted bin.
   typedef enum logic [1:0] {
      JOB_EDGE   = 2'd0,
      JOB_CENTER = 2'd1,
      JOB_DENS   = 2'd2
   } job_type;

endpackage

FILE: hw/rtl/equal_width_histogram_unit.sv
// Equal-width histogram: sample loading, binning pass and per-bin reporting.
//
// Samples enter on the req_ channel, one word per cycle while loading.
// Each sample that fits is written into the sample memory and the running minimum and
// maximum are updated. The word with req_sample_last closes the run: the
// count memory is cleared (one entry per cycle), then every
// stored sample is read back and binned. Bin numbers come from a shared
// restoring divider that resolves one quotient bit per cycle; the
// read-modify-write of the count memory is interlocked behind it. Then one
// word per bin leaves on the rsp_ channel; each needs three divider runs
// (edge, centre, density) and a handover through the EMIT and WAIT states.
// Loading is one sample per cycle; the input is stalled from the last
// sample until the final bin word has been taken.
// A stalled rsp_ word holds its value until taken; the block then waits.
// Synchronous reset returns to loading with bin_count 16 and an empty run;
// it needs no clearing pass since counts are cleared before each binning pass.
// csr_ writes bin_count (0 acts as 1, above MAX_BINS saturates); the user must write it while idle only, not enforced.
module equal_width_histogram_unit
   import ewh_pkg::*;
#(
   parameter int MAX_SAMPLES = 1024,
   parameter int MAX_BINS    = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_sample_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [5:0]                    rsp_bin_index,
   output logic signed [23:0]            rsp_bin_low_edge,
   output logic signed [23:0]            rsp_bin_center,
   output logic [10:0]                   rsp_bin_total,
   output logic [31:0]                   rsp_density,
   output logic [1:0]                    rsp_error_code,
   output logic                          rsp_last_bin,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [BIN_COUNT_W-1:0]        csr_bin_count
);

   localparam int SW   = SAMPLE_BITS;
   localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int NW   = $clog2(MAX_SAMPLES + 1);
   localparam int BW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int NBW  = $clog2(MAX_BINS + 1);
   localparam int RW   = SW + 1;
   // Dividend wide enough for count*B*65536 and for (2k+1)*range*128.
   localparam int DW   = (11 + NBW + 16 > RW + BW + 9) ? 11 + NBW + 16 : RW + BW + 9;
   localparam int VW   = NW + RW;
   localparam int QW   = DW;
   localparam int CW   = $clog2(DW + 1);
   localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

   state_type state_ff, state_in;

   logic [BIN_COUNT_W-1:0] bin_count_ff;
   logic signed [SW-1:0]   min_ff, max_ff;
   logic [NW-1:0]          loaded_ff;
   logic                   overflow_ff;

   // Memories.
   logic signed [SW-1:0] sample_mem [MAX_SAMPLES];
   logic [10:0]          count_mem [MAX_BINS];
   logic signed [SW-1:0] sample_rd_ff;
   logic [10:0]          count_rd_ff;
   logic [BW:0]          count_rd_addr;

   logic [NW-1:0]  idx_ff;
   logic [BW:0]    bin_ff;
   logic [NBW-1:0] nb_ff;
   logic [RW-1:0]  range_ff;
   logic           flat_ff;
   job_type        job_ff;
   logic           rd_wait_ff;

   // Divider.
   logic [DW-1:0] dvd_ff;
   logic [VW-1:0] dvs_ff;
   logic [VW:0]   rem_ff;
   logic [QW-1:0] quo_ff;
   logic [CW-1:0] dcnt_ff;
   logic          dbusy_ff;

   logic [5:0]         o_idx_ff;
   logic signed [23:0] o_lo_ff, o_ce_ff;
   logic [10:0]        o_tot_ff;
   logic [31:0]        o_den_ff;
   logic [1:0]         o_err_ff;
   logic               o_last_ff, o_valid_ff;

   logic req_fire, full;
   logic [NBW-1:0] nb_eff;
   logic signed [SW-1:0] x;

   assign x        = req_sample;
   assign req_stall = !state_ff[0];
   assign req_fire = req_valid && !req_stall;
   assign full     = (loaded_ff == NW'(MAX_SAMPLES));
   assign csr_ready = 1'b1;

   always_comb begin
      if (bin_count_ff == '0) nb_eff = NBW'(1);
      else if (32'(bin_count_ff) > MAX_BINS) nb_eff = NBW'(MAX_BINS);
      else nb_eff = NBW'(bin_count_ff);
   end

   // Divider trial subtraction, one quotient bit per cycle.
   logic [VW:0] rem_sh;
   logic        ge;
   assign rem_sh = {rem_ff[VW-1:0], dvd_ff[DW-1]};
   assign ge     = rem_sh >= {1'b0, dvs_ff};

   // Effective min and range of the closing run.
   logic signed [SW-1:0] run_min;
   logic [RW-1:0]        run_range;
   always_comb begin
      run_min   = (loaded_ff == '0) ? '0 : min_ff;
      run_range = (loaded_ff == '0) ? '0
                : RW'($signed({max_ff[SW-1], max_ff}) - $signed({min_ff[SW-1], min_ff}));
   end

   // Samples are stored and the counts read in clocked blocks.
   always_ff @(posedge clock) begin
      if (req_fire && !full) sample_mem[loaded_ff[AW-1:0]] <= x;
      sample_sample_rd: sample_rd_ff <= sample_mem[idx_ff[AW-1:0]];
      count_rd_ff <= count_mem[count_rd_addr[BW-1:0]];
      if (state_ff == ST_CLEAR) count_mem[bin_ff[BW-1:0]] <= '0;
      else if (state_ff == ST_BIN && dbusy_ff && dcnt_ff == '0 && !rd_wait_ff)
         count_mem[bin_ff[BW-1:0]] <= count_rd_ff + 11'd1;
   end

   // Bin of a settled quotient, clamped to the last bin.
   function automatic logic [BW:0] clamp_bin(input logic [QW-1:0] q,
                                             input logic [NBW-1:0] nb, input logic flat);
      logic [BW:0] r;
      if (flat || q >= QW'(nb)) r = (BW+1)'(nb - NBW'(1));
      else r = (BW+1)'(q);
      return r;
   endfunction

   logic [BW:0] bin_of_q;
   assign bin_of_q = clamp_bin({rem_ff[0] ? quo_ff : quo_ff}, nb_ff, flat_ff);

   // The count entry of a settled bin is read as soon as the quotient is known,
   // so the read data is ready for the increment in the following cycle.
   assign count_rd_addr = (state_ff == ST_BIN && dbusy_ff && dcnt_ff == '0 && rd_wait_ff)
                        ? bin_of_q : bin_ff;

   // Main sequencer.
   always_ff @(posedge clock) begin
      logic [DW-1:0] num;
      logic signed [SW+8:0] base;
      logic [VW-1:0] dv;
      if (reset) begin
         state_ff     <= ST_LOAD;
         bin_count_ff <= BIN_COUNT_RESET;
         min_ff       <= SMAX;
         max_ff       <= SMIN;
         loaded_ff    <= '0;
         overflow_ff  <= 1'b0;
         o_valid_ff   <= 1'b0;
         dbusy_ff     <= 1'b0;
         rd_wait_ff   <= 1'b0;
         idx_ff       <= '0;
         bin_ff       <= '0;
      end else begin
         num  = '0;
         dv   = '0;
         base = $signed({min_ff, 8'd0});
         if (csr_valid && csr_ready) bin_count_ff <= csr_bin_count;
         if (o_valid_ff && !rsp_stall) o_valid_ff <= 1'b0;

         // Divider step.
         if (dbusy_ff && dcnt_ff != '0) begin
            rem_ff  <= ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
            quo_ff  <= {quo_ff[QW-2:0], ge};
            dvd_ff  <= {dvd_ff[DW-2:0], 1'b0};
            dcnt_ff <= dcnt_ff - CW'(1);
         end

         unique case (state_ff)
            ST_LOAD: begin
               if (req_fire) begin
                  if (!full) begin
                     loaded_ff <= loaded_ff + NW'(1);
                     if (x < min_ff) min_ff <= x;
                     if (x > max_ff) max_ff <= x;
                  end else begin
                     overflow_ff <= 1'b1;
                  end
                  if (req_sample_last) begin
                     state_ff <= ST_CLEAR;
                     bin_ff   <= '0;
                  end
               end
            end
            ST_CLEAR: begin
               // Latch run geometry once stores have settled.
               min_ff   <= run_min;
               range_ff <= run_range;
               flat_ff  <= (run_range == '0);
               nb_ff    <= nb_eff;
               if (bin_ff == (BW+1)'(MAX_BINS - 1)) begin
                  idx_ff     <= '0;
                  state_ff   <= (loaded_ff == '0) ? ST_DIV : ST_FETCH;
                  bin_ff     <= '0;
                  job_ff     <= JOB_EDGE;
                  rd_wait_ff <= 1'b1;
               end else begin
                  bin_ff <= bin_ff + (BW+1)'(1);
               end
            end
            ST_FETCH: begin
               // Wait for the registered sample memory read.
               rd_wait_ff <= 1'b0;
               state_ff   <= ST_BIN;
            end
            ST_BIN: begin
               if (!dbusy_ff) begin
                  // Start (x-min)*B / range.
                  num      = DW'(RW'($signed({sample_rd_ff[SW-1], sample_rd_ff})
                                - $signed({min_ff[SW-1], min_ff})) * nb_ff);
                  dvd_ff   <= num;
                  dvs_ff   <= VW'(flat_ff ? RW'(1) : range_ff);
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  dcnt_ff  <= CW'(DW);
                  dbusy_ff <= 1'b1;
                  rd_wait_ff <= 1'b1;
               end else if (dcnt_ff == '0) begin
                  if (rd_wait_ff) begin
                     // Address the count entry, read lands next cycle.
                     bin_ff     <= bin_of_q;
                     rd_wait_ff <= 1'b0;
                  end else begin
                     dbusy_ff <= 1'b0;
                     if (idx_ff + NW'(1) == loaded_ff) begin
                        state_ff   <= ST_DIV;
                        bin_ff     <= '0;
                        job_ff     <= JOB_EDGE;
                        rd_wait_ff <= 1'b1;
                     end else begin
                        idx_ff   <= idx_ff + NW'(1);
                        state_ff <= ST_FETCH;
                        rd_wait_ff <= 1'b1;
                     end
                  end
               end
            end
            ST_DIV: begin
               if (!dbusy_ff) begin
                  unique case (job_ff)
                     JOB_EDGE: begin
                        num = DW'(bin_ff) * DW'(range_ff) * DW'(256);
                        dv  = VW'(nb_ff);
                     end
                     JOB_CENTER: begin
                        num = DW'({bin_ff, 1'b1}) * DW'(range_ff) * DW'(128);
                        dv  = VW'(nb_ff);
                     end
                     JOB_DENS: begin
                        num = DW'(count_rd_ff) * DW'(nb_ff) * DW'(65536);
                        dv  = VW'(loaded_ff) * VW'(flat_ff ? RW'(1) : range_ff);
                     end
                     default: begin
                        num = '0;
                        dv  = VW'(1);
                     end
                  endcase
                  dvd_ff   <= num;
                  dvs_ff   <= dv;
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  dcnt_ff  <= CW'(DW);
                  dbusy_ff <= 1'b1;
               end else if (dcnt_ff == '0) begin
                  dbusy_ff <= 1'b0;
                  unique case (job_ff)
                     JOB_EDGE: begin
                        o_lo_ff <= 24'(base + $signed({1'b0, quo_ff[SW+8:0]}));
                        job_ff  <= JOB_CENTER;
                     end
                     JOB_CENTER: begin
                        o_ce_ff <= 24'(base + $signed({1'b0, quo_ff[SW+8:0]}));
                        job_ff  <= JOB_DENS;
                     end
                     JOB_DENS: begin
                        if (flat_ff || loaded_ff == '0) o_den_ff <= '0;
                        else if (|quo_ff[QW-1:32]) o_den_ff <= '1;
                        else o_den_ff <= quo_ff[31:0];
                        o_tot_ff  <= count_rd_ff;
                        o_idx_ff  <= 6'(bin_ff);
                        o_last_ff <= (bin_ff == (BW+1)'(nb_ff - NBW'(1)));
                        o_err_ff  <= flat_ff ? ERR_FLAT
                                   : (overflow_ff ? ERR_DROPPED : ERR_NONE);
                        state_ff  <= ST_EMIT;
                     end
                     default: job_ff <= JOB_EDGE;
                  endcase
               end
            end
            ST_EMIT: begin
               if (!o_valid_ff) begin
                  o_valid_ff <= 1'b1;
                  state_ff   <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (o_valid_ff && !rsp_stall) begin
                  if (o_last_ff) begin
                     state_ff    <= ST_LOAD;
                     min_ff      <= SMAX;
                     max_ff      <= SMIN;
                     loaded_ff   <= '0;
                     overflow_ff <= 1'b0;
                  end else begin
                     bin_ff   <= bin_ff + (BW+1)'(1);
                     job_ff   <= JOB_EDGE;
                     state_ff <= ST_DIV;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   assign rsp_valid        = o_valid_ff;
   assign rsp_bin_index    = o_idx_ff;
   assign rsp_bin_low_edge = o_lo_ff;
   assign rsp_bin_center   = o_ce_ff;
   assign rsp_bin_total    = o_tot_ff;
   assign rsp_density      = o_den_ff;
   assign rsp_error_code   = o_err_ff;
   assign rsp_last_bin     = o_last_ff;

   // Input is only taken while loading.
   a_stall_outside_load: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_LOAD |-> req_stall) else $error("input taken outside load");
   // The sample count never exceeds the memory depth.
   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      32'(loaded_ff) <= MAX_SAMPLES) else $error("sample count overrun");
   // A result word only appears while reporting.
   a_valid_in_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_WAIT || state_ff == ST_EMIT))
      else $error("result outside reporting");
   // The divider never runs during loading.
   a_div_idle_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> !dbusy_ff) else $error("divider busy in load");

endmodule
